// ----- rtl/sv39ptw_pkg.sv -----
`timescale 1ns / 1ps

package sv39ptw_pkg;

  localparam int unsigned VA_W   = 39;
  localparam int unsigned PPN_W  = 44;
  localparam int unsigned PA_W   = 56;
  localparam int unsigned PTE_W  = 64;
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned OFS_W  = 12;
  localparam int unsigned LVL_W  = 2;

  localparam int unsigned PTE_V  = 0;
  localparam int unsigned PTE_R  = 1;
  localparam int unsigned PTE_W_BIT = 2;
  localparam int unsigned PTE_X  = 3;
  localparam int unsigned PTE_PPN_LO = 10;

  localparam logic [LVL_W-1:0] LVL_TOP  = 2'd2;
  localparam logic [LVL_W-1:0] LVL_LEAF = 2'd0;

  localparam logic FUNC_TRANSLATE = 1'b0;
  localparam logic FUNC_PTE       = 1'b1;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    FLT_NONE      = 3'd0,
    FLT_INVALID   = 3'd1,
    FLT_W_NO_R    = 3'd2,
    FLT_SUPERPAGE = 3'd3,
    FLT_NO_LEAF   = 3'd4
  } fault_t;

  typedef struct packed {
    logic              vld;
    kind_t             kind;
    logic [PA_W-1:0]   read_addr;
    logic [PA_W-1:0]   phys_addr;
    fault_t            fault_code;
  } result_t;

  function automatic logic [IDX_W-1:0] vpn_at(input logic [VA_W-1:0] va,
                                             input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    idx = '0;
    unique case (lvl)
      2'd0:    idx = va[OFS_W +: IDX_W];
      2'd1:    idx = va[OFS_W+IDX_W +: IDX_W];
      2'd2:    idx = va[OFS_W+2*IDX_W +: IDX_W];
      default: idx = '0;
    endcase
    return idx;
  endfunction

endpackage

// ----- rtl/sv39ptw_cfg.sv -----
`timescale 1ns / 1ps

module sv39ptw_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [3:0]                     cfg_paddr,
  input  logic [63:0]                    cfg_pwdata,
  output logic [63:0]                    cfg_prdata,
  output logic                           cfg_pready,
  output logic [sv39ptw_pkg::PPN_W-1:0]  root_pn
);

  logic [sv39ptw_pkg::PPN_W-1:0] root_pn_r;
  logic [sv39ptw_pkg::PPN_W-1:0] root_pn_nxt;
  logic                          wr_root;

  assign cfg_pready = 1'b1;
  assign wr_root    = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & ~cfg_paddr[3];

  always_comb begin
    root_pn_nxt = root_pn_r;
    if (wr_root) begin
      root_pn_nxt = cfg_pwdata[sv39ptw_pkg::PPN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_pn_r <= '0;
    end else begin
      root_pn_r <= root_pn_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (!cfg_paddr[3]) begin
      cfg_prdata = {{(64-sv39ptw_pkg::PPN_W){1'b0}}, root_pn_r};
    end
  end

  assign root_pn = root_pn_r;

endmodule

// ----- rtl/sv39ptw_walk.sv -----
`timescale 1ns / 1ps

module sv39ptw_walk (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  logic                           func,
  input  logic [sv39ptw_pkg::VA_W-1:0]   virt_addr,
  input  logic [sv39ptw_pkg::PTE_W-1:0]  pte_word,
  input  logic [sv39ptw_pkg::PPN_W-1:0]  root_pn,
  output sv39ptw_pkg::result_t           res
);

  logic                          walk_busy_r,   walk_busy_nxt;
  logic [sv39ptw_pkg::LVL_W-1:0] walk_level_r,  walk_level_nxt;
  logic [sv39ptw_pkg::PPN_W-1:0] table_page_r,  table_page_nxt;
  logic [sv39ptw_pkg::VA_W-1:0]  saved_vaddr_r, saved_vaddr_nxt;

  logic [sv39ptw_pkg::PPN_W-1:0] pte_ppn;
  logic [sv39ptw_pkg::LVL_W-1:0] lvl_down;
  logic                          pte_v, pte_r, pte_w, pte_x, pte_leaf;

  assign pte_ppn  = pte_word[sv39ptw_pkg::PTE_PPN_LO +: sv39ptw_pkg::PPN_W];
  assign pte_v    = pte_word[sv39ptw_pkg::PTE_V];
  assign pte_r    = pte_word[sv39ptw_pkg::PTE_R];
  assign pte_w    = pte_word[sv39ptw_pkg::PTE_W_BIT];
  assign pte_x    = pte_word[sv39ptw_pkg::PTE_X];
  assign pte_leaf = pte_r | pte_w | pte_x;
  assign lvl_down = walk_level_r - 2'd1;

  always_comb begin
    walk_busy_nxt   = walk_busy_r;
    walk_level_nxt  = walk_level_r;
    table_page_nxt  = table_page_r;
    saved_vaddr_nxt = saved_vaddr_r;
    res             = '0;
    res.kind        = sv39ptw_pkg::KIND_READ;
    res.fault_code  = sv39ptw_pkg::FLT_NONE;
    if (step_en) begin
      if (func == sv39ptw_pkg::FUNC_TRANSLATE) begin
        if (!walk_busy_r) begin
          saved_vaddr_nxt = virt_addr;
          table_page_nxt  = root_pn;
          walk_level_nxt  = sv39ptw_pkg::LVL_TOP;
          walk_busy_nxt   = 1'b1;
          res.vld         = 1'b1;
          res.kind        = sv39ptw_pkg::KIND_READ;
          res.read_addr   = {root_pn, sv39ptw_pkg::vpn_at(virt_addr, sv39ptw_pkg::LVL_TOP),
                             3'b000};
        end
      end else if (walk_busy_r) begin
        res.vld = 1'b1;
        priority if (!pte_v) begin
          res.kind       = sv39ptw_pkg::KIND_FAULT;
          res.fault_code = sv39ptw_pkg::FLT_INVALID;
        end else if (!pte_r && pte_w) begin
          res.kind       = sv39ptw_pkg::KIND_FAULT;
          res.fault_code = sv39ptw_pkg::FLT_W_NO_R;
        end else if (pte_leaf && walk_level_r != sv39ptw_pkg::LVL_LEAF) begin
          res.kind       = sv39ptw_pkg::KIND_FAULT;
          res.fault_code = sv39ptw_pkg::FLT_SUPERPAGE;
        end else if (pte_leaf) begin
          res.kind      = sv39ptw_pkg::KIND_DONE;
          res.phys_addr = {pte_ppn, saved_vaddr_r[sv39ptw_pkg::OFS_W-1:0]};
        end else if (walk_level_r == sv39ptw_pkg::LVL_LEAF) begin
          res.kind       = sv39ptw_pkg::KIND_FAULT;
          res.fault_code = sv39ptw_pkg::FLT_NO_LEAF;
        end else begin
          res.kind       = sv39ptw_pkg::KIND_READ;
          res.read_addr  = {pte_ppn, sv39ptw_pkg::vpn_at(saved_vaddr_r, lvl_down), 3'b000};
          table_page_nxt = pte_ppn;
          walk_level_nxt = lvl_down;
        end
        if (res.kind != sv39ptw_pkg::KIND_READ) begin
          walk_busy_nxt  = 1'b0;
          walk_level_nxt = sv39ptw_pkg::LVL_TOP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_busy_r   <= 1'b0;
      walk_level_r  <= sv39ptw_pkg::LVL_TOP;
      table_page_r  <= '0;
      saved_vaddr_r <= '0;
    end else begin
      walk_busy_r   <= walk_busy_nxt;
      walk_level_r  <= walk_level_nxt;
      table_page_r  <= table_page_nxt;
      saved_vaddr_r <= saved_vaddr_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && res.kind != sv39ptw_pkg::KIND_READ) |=> !walk_busy_r)
    else $error("walk still busy after done or fault");

  a_read_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && res.kind == sv39ptw_pkg::KIND_READ) |=> walk_busy_r)
    else $error("walk idle after issuing a read request");

  a_idle_level_top: assert property (@(posedge clk) disable iff (!rst_n)
    !walk_busy_r |-> walk_level_r == sv39ptw_pkg::LVL_TOP)
    else $error("idle walker not at top level");

  a_fault_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> ((res.kind == sv39ptw_pkg::KIND_FAULT) ==
                 (res.fault_code != sv39ptw_pkg::FLT_NONE)))
    else $error("fault code disagrees with result kind");
`endif

endmodule

// ----- rtl/sv39_page_table_walker.sv -----
`timescale 1ns / 1ps
// sv39 page table walker, 4 KiB pages only, three levels
// in_ channel: func 0 starts a translation of in_virt_addr, func 1 returns
//   the page table entry in in_pte_word for the last read request issued
// out_ channel: kind 0 asks for a 64-bit entry at out_read_addr, kind 1
//   gives the translated out_phys_addr, kind 2 gives out_fault_code
// a translation while a walk is running, or an entry while idle, is
//   dropped and gives no result
// cfg_ port: root page number at address 0, to be written only while the
//   walker idles; the block itself does not enforce this
// throughput: one request per cycle while out_ready is high, set by the
// input and result registers with one step of combinational checks between them
// receiver stall: the result register holds, the input register fills,
//   then in_ready drops until out_ready returns
// reset (synchronous rst_n low): walker idle, root page number zero,
//   both registers empty

module sv39_page_table_walker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [sv39ptw_pkg::VA_W-1:0]   in_virt_addr,
  input  logic [sv39ptw_pkg::PTE_W-1:0]  in_pte_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_kind,
  output logic [sv39ptw_pkg::PA_W-1:0]   out_read_addr,
  output logic [sv39ptw_pkg::PA_W-1:0]   out_phys_addr,
  output logic [2:0]                     out_fault_code,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [3:0]                     cfg_paddr,
  input  logic [63:0]                    cfg_pwdata,
  output logic [63:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  logic                          in_vld_r,   in_vld_nxt;
  logic                          in_func_r;
  logic [sv39ptw_pkg::VA_W-1:0]  in_vaddr_r;
  logic [sv39ptw_pkg::PTE_W-1:0] in_pte_r;
  logic                          out_vld_r,  out_vld_nxt;
  sv39ptw_pkg::result_t          out_r;
  sv39ptw_pkg::result_t          res;
  logic [sv39ptw_pkg::PPN_W-1:0] root_pn;
  logic                          step_en;
  logic                          in_acc;

  sv39ptw_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .root_pn     (root_pn)
  );

  sv39ptw_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .func      (in_func_r),
    .virt_addr (in_vaddr_r),
    .pte_word  (in_pte_r),
    .root_pn   (root_pn),
    .res       (res)
  );

  assign step_en  = in_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~in_vld_r | step_en;
  assign in_acc   = in_valid & in_ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (step_en) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (step_en) begin
      out_vld_nxt = res.vld;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_func_r  <= in_func;
      in_vaddr_r <= in_virt_addr;
      in_pte_r   <= in_pte_word;
    end
    if (step_en) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_kind       = out_r.kind;
  assign out_read_addr  = out_r.read_addr;
  assign out_phys_addr  = out_r.phys_addr;
  assign out_fault_code = out_r.fault_code;

endmodule
